// ===== rtl/kth_smallest_in_product_table_defines.svh =====
// ----------------------------------------------------------------------------
// kth_smallest_in_product_table assertion macros
// Concurrent assertion helpers, compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef KTH_SMALLEST_IN_PRODUCT_TABLE_DEFINES_SVH
`define KTH_SMALLEST_IN_PRODUCT_TABLE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset.
`define KTS_ASSERT_IMPLIES(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("kts assertion failed");

// Next-cycle implication, disabled during reset.
`define KTS_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("kts assertion failed");

`else

`define KTS_ASSERT_IMPLIES(label, clk, rst_n, cond, expr)
`define KTS_ASSERT_NEXT(label, clk, rst_n, cond, expr)

`endif

`endif

// ===== rtl/kts_pkg.sv =====
// ----------------------------------------------------------------------------
// kts_pkg
// Shared widths, types and sequencer states for the product-table rank search.
// ----------------------------------------------------------------------------
package kts_pkg;

    // Table dimensions are taken in their low DIM_BITS bits.
    localparam int DIM_BITS = 16;
    localparam int IDX_W    = DIM_BITS + 1;
    localparam int PROD_W   = 2 * DIM_BITS;
    localparam int RANK_W   = 32;
    localparam int VALUE_W  = 32;
    localparam int CMP_W    = (PROD_W > RANK_W) ? PROD_W : RANK_W;

    // Input word field layout.
    localparam int FIELD_W  = 16;
    localparam int ROWS_LSB = 0;
    localparam int COLS_LSB = 16;
    localparam int RANK_LSB = 32;
    localparam int IN_W     = 64;

    typedef logic [DIM_BITS-1:0] dim_t;
    typedef logic [IDX_W-1:0]    idx_t;
    typedef logic [PROD_W-1:0]   prod_t;
    typedef logic [RANK_W-1:0]   rank_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_PROBE,
        S_WAIT,
        S_DONE
    } state_t;

    // Sequencer to counting unit.
    typedef struct packed {
        logic  start;
        prod_t x;
    } cnt_req_t;

    // Counting unit to sequencer.
    typedef struct packed {
        logic busy;
        logic done;
        logic reach;
    } cnt_rsp_t;

endpackage

// ===== rtl/kts_count.sv =====
// ----------------------------------------------------------------------------
// kts_count
// Staircase counter: decides whether the number of table entries <= x reaches
// the wanted rank, one staircase step per cycle.
// ----------------------------------------------------------------------------
module kts_count
    import kts_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cnt_req_t req,
    input  dim_t     shorter,
    input  dim_t     longer,
    input  rank_t    want,
    output cnt_rsp_t rsp
);

    // p tracks i*j so no multiplier is needed in the loop.
    logic  busy_reg,  busy_next;
    logic  done_reg,  done_next;
    logic  reach_reg, reach_next;
    idx_t  i_reg,     i_next;
    dim_t  j_reg,     j_next;
    prod_t p_reg,     p_next;
    prod_t total_reg, total_next;
    prod_t x_reg,     x_next;

    logic reach_now;
    logic end_now;
    logic step_up;

    assign reach_now = CMP_W'(total_reg) >= CMP_W'(want);
    assign end_now   = (i_reg > IDX_W'(shorter)) || (j_reg == '0);
    assign step_up   = p_reg <= x_reg;

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        reach_next = reach_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        p_next     = p_reg;
        total_next = total_reg;
        x_next     = x_reg;
        if (!busy_reg)
        begin
            if (req.start)
            begin
                busy_next  = 1'b1;
                i_next     = IDX_W'(1);
                j_next     = longer;
                p_next     = PROD_W'(longer);
                total_next = '0;
                x_next     = req.x;
            end
        end
        else if (reach_now)
        begin
            // count only grows, so stop as soon as the rank is reached
            busy_next  = 1'b0;
            done_next  = 1'b1;
            reach_next = 1'b1;
        end
        else if (end_now)
        begin
            busy_next  = 1'b0;
            done_next  = 1'b1;
            reach_next = 1'b0;
        end
        else if (step_up)
        begin
            // row i contributes j entries; move to next row
            total_next = total_reg + PROD_W'(j_reg);
            p_next     = p_reg + PROD_W'(j_reg);
            i_next     = i_reg + IDX_W'(1);
        end
        else
        begin
            p_next = p_reg - PROD_W'(i_reg);
            j_next = j_reg - DIM_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        reach_reg <= reach_next;
        i_reg     <= i_next;
        j_reg     <= j_next;
        p_reg     <= p_next;
        total_reg <= total_next;
        x_reg     <= x_next;
    end

    assign rsp.busy  = busy_reg;
    assign rsp.done  = done_reg;
    assign rsp.reach = reach_reg;

endmodule

// ===== rtl/kth_smallest_in_product_table.sv =====
// ----------------------------------------------------------------------------
// kth_smallest_in_product_table
// Finds the k-th smallest entry of a rows-by-cols multiplication table.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_axis_*: one word carries rows, cols and rank. The block
//   takes a word only when idle (s_axis_tready high) and then works on it
//   alone until its result is loaded into the output register.
//   Output channel m_axis_*: tdata is the table entry, tuser[0] is found.
//   A zero dimension or a rank beyond rows*cols gives value 0, found 0;
//   rank 0 gives value 1.
//   Search: a binary search over 1..rows*cols of at most 2*DIM_BITS
//   probes; each probe runs the staircase counter, one step per cycle,
//   and stops early once the rank is reached.
//   Overlap: a word is taken only once the previous one is finished; the
//   next is taken while that result still waits in the output register.
//   Stall: if the previous result has not been taken when a new one is
//   finished, the sequencer holds in its done state until m_axis_tready.
//   Reset: asynchronous, active low; the block comes up idle with no
//   pending result.
// ----------------------------------------------------------------------------
`include "kth_smallest_in_product_table_defines.svh"

module kth_smallest_in_product_table
    import kts_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [IN_W-1:0]    s_axis_tdata,   // rows[15:0], cols[31:16], rank[63:32]
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [VALUE_W-1:0] m_axis_tdata,   // value[31:0]
    output logic [0:0]         m_axis_tuser    // found[0]
);

    state_t state_reg, state_next;

    // Dimensions are ordered on entry so the row loop is the short one.
    dim_t  short_reg, short_next;
    dim_t  long_reg,  long_next;
    rank_t want_reg,  want_next;

    // Search window and best candidate so far.
    prod_t lo_reg,    lo_next;
    prod_t hi_reg,    hi_next;
    prod_t mid_reg,   mid_next;
    prod_t best_reg,  best_next;
    logic  hit_reg,   hit_next;

    // Output register.
    logic               out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0] value_reg,     value_next;
    logic               found_reg,     found_next;

    dim_t     in_rows;
    dim_t     in_cols;
    prod_t    mid_calc;
    logic     out_free;
    cnt_req_t cnt_req;
    cnt_rsp_t cnt_rsp;

    assign in_rows  = DIM_BITS'(s_axis_tdata[ROWS_LSB +: FIELD_W]);
    assign in_cols  = DIM_BITS'(s_axis_tdata[COLS_LSB +: FIELD_W]);
    assign mid_calc = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign out_free = !out_valid_reg || m_axis_tready;

    assign s_axis_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        short_next     = short_reg;
        long_next      = long_reg;
        want_next      = want_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        best_next      = best_reg;
        hit_next       = hit_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        value_next     = value_reg;
        found_next     = found_reg;
        cnt_req.start  = 1'b0;
        cnt_req.x      = mid_calc;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    short_next = (in_rows < in_cols) ? in_rows : in_cols;
                    long_next  = (in_rows < in_cols) ? in_cols : in_rows;
                    want_next  = s_axis_tdata[RANK_LSB +: RANK_W];
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                lo_next    = PROD_W'(1);
                hi_next    = PROD_W'(short_reg) * PROD_W'(long_reg);
                best_next  = '0;
                hit_next   = 1'b0;
                state_next = S_PROBE;
            end
            S_PROBE:
            begin
                if (lo_reg > hi_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    mid_next      = mid_calc;
                    cnt_req.start = 1'b1;
                    state_next    = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (cnt_rsp.done)
                begin
                    if (cnt_rsp.reach)
                    begin
                        best_next = mid_reg;
                        hit_next  = 1'b1;
                        hi_next   = mid_reg - PROD_W'(1);
                    end
                    else
                    begin
                        lo_next = mid_reg + PROD_W'(1);
                    end
                    state_next = S_PROBE;
                end
            end
            S_DONE:
            begin
                // hold until the output register is free
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    value_next     = VALUE_W'(best_reg);
                    found_next     = hit_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        short_reg <= short_next;
        long_reg  <= long_next;
        want_reg  <= want_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        mid_reg   <= mid_next;
        best_reg  <= best_next;
        hit_reg   <= hit_next;
        value_reg <= value_next;
        found_reg <= found_next;
    end

    kts_count u_count
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (cnt_req),
        .shorter (short_reg),
        .longer  (long_reg),
        .want    (want_reg),
        .rsp     (cnt_rsp)
    );

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = value_reg;
    assign m_axis_tuser[0] = found_reg;

    // Counter only runs while the sequencer waits on it.
    `KTS_ASSERT_IMPLIES(a_busy_in_wait, clk, rst_n, cnt_rsp.busy, state_reg == S_WAIT)
    // A finished result lands in the output register on the next cycle.
    `KTS_ASSERT_NEXT(a_result_loaded, clk, rst_n, (state_reg == S_DONE) && out_free, out_valid_reg)
    // Search lower bound never drops to zero.
    `KTS_ASSERT_IMPLIES(a_lo_positive, clk, rst_n, state_reg == S_PROBE, lo_reg != '0)
    // A found entry is never zero.
    `KTS_ASSERT_IMPLIES(a_found_nonzero, clk, rst_n, out_valid_reg && found_reg, value_reg != '0)

endmodule

// ===== dv/kth_smallest_in_product_table_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kth_smallest_in_product_table_tb
// Stream-level testbench for the product-table rank search. Each query word
// is scored against an in-bench binary-search model as it is accepted; each
// result word is checked in order. Directed corner queries come first, then
// random queries, under three back-pressure mixes and one long sink stall.
// ----------------------------------------------------------------------------
module kth_smallest_in_product_table_tb
    import kts_pkg::*;
();

    // Query word as it sits on s_axis_tdata: rows lowest, rank highest.
    typedef struct packed {
        rank_t rank;
        dim_t  cols;
        dim_t  rows;
    } table_query_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               found;
    } table_answer_t;

    // Back-pressure mix, stepped by how many query words have been taken.
    typedef enum logic [1:0] {
        PH_SINK_SLOW,
        PH_SOURCE_SLOW,
        PH_FULL_RATE
    } pace_t;

    localparam int RANDOM_QUERIES = 100;
    // Worst directed query (4096 x 2) is at most 14 probes of the counter;
    // the long sink stall also stays far below this limit.
    localparam int IDLE_LIMIT     = 200_000;
    localparam int DRAIN_CYCLES   = 200;
    localparam int STALL_AFTER    = 30;     // results seen before the long stall
    localparam int STALL_CYCLES   = 20_000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [IN_W-1:0]    s_axis_tdata = '0;      // rows[15:0], cols[31:16], rank[63:32]
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [VALUE_W-1:0] m_axis_tdata;           // value[31:0]
    logic [0:0]         m_axis_tuser;           // found[0]

    table_query_t  query_queue[$];      // built up front, drained by the driver
    table_answer_t answers_due[$];      // one per accepted query, oldest first
    int            query_total = 0;
    int            queries_taken = 0;
    int            answers_seen = 0;
    int            mismatches = 0;
    int            sink_hold = 0;
    int            idle_cycles = 0;

    kth_smallest_in_product_table DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Model
    // ------------------------------------------------------------------

    // How many table entries are <= x, walking rows of the short side.
    function automatic logic [63:0] entries_at_most(input logic [63:0] x,
                                                    input logic [63:0] shorter,
                                                    input logic [63:0] longer);
        logic [63:0] total;
        logic [63:0] last;
        logic [63:0] q;
        total = '0;
        last  = (x < shorter) ? x : shorter;
        for (logic [63:0] i = 64'd1; i <= last; i++)
        begin
            q = x / i;
            total += (q < longer) ? q : longer;
        end
        return total;
    endfunction

    // Least x in 1..rows*cols with at least rank entries <= x.
    function automatic table_answer_t kth_table_entry(input table_query_t qry);
        logic [63:0]   shorter;
        logic [63:0]   longer;
        logic [63:0]   lo;
        logic [63:0]   hi;
        logic [63:0]   mid;
        table_answer_t ans;
        shorter   = 64'((qry.rows < qry.cols) ? qry.rows : qry.cols);
        longer    = 64'((qry.rows < qry.cols) ? qry.cols : qry.rows);
        lo        = 64'd1;
        hi        = shorter * longer;
        ans.value = '0;
        ans.found = 1'b0;
        while (lo <= hi)
        begin
            mid = lo + ((hi - lo) >> 1);
            if (entries_at_most(mid, shorter, longer) >= {32'd0, qry.rank})
            begin
                ans.value = mid[VALUE_W-1:0];
                ans.found = 1'b1;
                hi = mid - 64'd1;
            end
            else
            begin
                lo = mid + 64'd1;
            end
        end
        return ans;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic add_query(input int unsigned r, input int unsigned c,
                             input int unsigned k);
        table_query_t qry;
        qry.rows = dim_t'(r);
        qry.cols = dim_t'(c);
        qry.rank = rank_t'(k);
        query_queue = {query_queue, qry};
    endtask

    // Mostly tiny sides so the search stays short; a few wider, a few empty.
    function automatic int unsigned pick_side();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 4)
            return 0;
        else if (roll < 10)
            return $urandom_range(21, 200);
        else
            return $urandom_range(1, 20);
    endfunction

    // Rank: mostly inside the table, with zero, just-past-the-end and wild.
    function automatic int unsigned pick_rank(input int unsigned r, input int unsigned c);
        int unsigned size;
        int unsigned roll;
        size = r * c;
        roll = $urandom_range(0, 99);
        if (roll < 70 && size > 0)
            return $urandom_range(1, size);
        else if (roll < 80)
            return 0;
        else if (roll < 90)
            return size + $urandom_range(1, 3);
        else
            return $urandom;
    endfunction

    function automatic pace_t current_pace();
        if (queries_taken < query_total / 3)
            return PH_SINK_SLOW;
        else if (queries_taken < (2 * query_total) / 3)
            return PH_SOURCE_SLOW;
        else
            return PH_FULL_RATE;
    endfunction

    function automatic bit source_idles();
        case (current_pace())
            PH_SINK_SLOW:   return $urandom_range(0, 99) < 29;
            PH_SOURCE_SLOW: return $urandom_range(0, 99) < 70;
            default:        return 1'b0;
        endcase
    endfunction

    function automatic bit sink_idles();
        case (current_pace())
            PH_SINK_SLOW:   return $urandom_range(0, 99) < 70;
            PH_SOURCE_SLOW: return $urandom_range(0, 99) < 29;
            default:        return 1'b0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driver: one word held until taken; model scored at acceptance.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                answers_due = {answers_due, kth_table_entry(table_query_t'(s_axis_tdata))};
                queries_taken++;
            end
            // Free to change the word only when nothing is held unaccepted.
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (query_queue.size() > 0 && !source_idles())
                begin
                    s_axis_tdata  <= query_queue[0];
                    query_queue.delete(0);
                    s_axis_tvalid <= 1'b1;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor and sink: in-order compare, random ready, one long hold-off.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        table_answer_t due;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (answers_due.size() == 0)
                begin
                    $error("result word with no query pending: value %0d found %0d",
                           m_axis_tdata, m_axis_tuser[0]);
                    mismatches++;
                end
                else
                begin
                    due = answers_due[0];
                    answers_due.delete(0);
                    if (m_axis_tdata !== due.value)
                    begin
                        $error("value: expected %0d, got %0d", due.value, m_axis_tdata);
                        mismatches++;
                    end
                    if (m_axis_tuser[0] !== due.found)
                    begin
                        $error("found: expected %0d, got %0d", due.found, m_axis_tuser[0]);
                        mismatches++;
                    end
                end
                answers_seen++;
                // Long stall: the block parks a result and takes one more query,
                // then has to back up its input while the driver keeps offering.
                if (answers_seen == STALL_AFTER)
                    sink_hold = STALL_CYCLES;
            end
            if (sink_hold > 0)
            begin
                sink_hold--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= !sink_idles();
            end
        end
    end

    // Watchdog: a stretch with no word moving on either side ends the run.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("FAIL kth_smallest_in_product_table");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Query list, reset, end of run
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned r;
        int unsigned c;

        // Smallest table, rank zero, rank one past the end.
        add_query(1, 1, 1);
        add_query(1, 1, 0);
        add_query(1, 1, 2);
        // Small tables, both orientations, last entry and one past it.
        add_query(3, 3, 5);
        add_query(2, 3, 6);
        add_query(3, 2, 6);
        add_query(7, 5, 35);
        add_query(5, 7, 36);
        add_query(12, 12, 0);
        add_query(12, 12, 77);
        // Empty table: zero on either side, any rank gives not found.
        add_query(0, 5, 0);
        add_query(16'hFFFF, 0, 1);
        add_query(0, 16'hFFFF, 32'hFFFF_FFFF);
        add_query(0, 0, 0);
        // Top rank on a small table.
        add_query(5, 7, 32'hFFFF_FFFF);
        // Long thin and wide square tables.
        add_query(1, 300, 150);
        add_query(300, 1, 1);
        add_query(4096, 2, 4096);
        add_query(1000, 1000, 500000);

        for (int n = 0; n < RANDOM_QUERIES; n++)
        begin
            r = pick_side();
            c = pick_side();
            add_query(r, c, pick_rank(r, c));
        end
        query_total = query_queue.size();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (query_queue.size() != 0 || s_axis_tvalid || answers_due.size() != 0)
            @(posedge clk);
        // Catch any stray extra result word.
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && answers_due.size() == 0)
        begin
            $display("PASS kth_smallest_in_product_table");
        end
        else
        begin
            if (answers_due.size() != 0)
                $error("%0d results never arrived", answers_due.size());
            $display("FAIL kth_smallest_in_product_table");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/kts_pkg.sv
rtl/kts_count.sv
rtl/kth_smallest_in_product_table.sv
dv/kth_smallest_in_product_table_tb.sv
